// ===== hw/rtl/sgdm_pkg.sv =====
// Shared types, constants and fixed-point helpers for the SGD momentum update core.
package sgdm_pkg;

  localparam int IDX_W            = 12;
  localparam int DATA_W           = 32;
  localparam int COEF_W           = 24;
  localparam int CFG_IDX_W        = 2;
  localparam int IN_TDATA_W       = 80;
  localparam int OUT_TDATA_W      = 80;
  localparam int NUM_ELEMENTS_DEF = 4096;
  localparam int OUT_FIFO_DEPTH   = 16;
  localparam int FIFO_PTR_W       = $clog2(OUT_FIFO_DEPTH);
  localparam int FIFO_CNT_W       = FIFO_PTR_W + 1;

  localparam logic [COEF_W-1:0] LR_RESET = 24'd167772;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LR    = 2'd0,
    REG_MOM   = 2'd1,
    REG_DECAY = 2'd2,
    REG_NEST  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] new_param;
    logic signed [DATA_W-1:0] new_velocity;
    logic                     saturated;
  } result_t;

  // Q16.16 (34-bit headroom) times unsigned Q0.24 (up to 2^24), exact.
  function automatic logic signed [57:0] mul_q24(input logic signed [33:0] a,
                                                 input logic [24:0] c);
    logic signed [57:0] ae;
    logic signed [57:0] ce;
    ae = 58'(a);
    ce = 58'($signed({1'b0, c}));
    return ae * ce;
  endfunction

  // Round to nearest, ties toward +inf, back to Q16.16.
  function automatic logic signed [33:0] round_q24(input logic signed [57:0] p);
    logic signed [57:0] t;
    t = p + 58'sd8388608;
    return $signed(t[57:24]);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    if (x > 34'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -34'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return x[31:0];
    end
  endfunction

  function automatic logic clip32(input logic signed [33:0] x);
    return (x > 34'sd2147483647) || (x < -34'sd2147483648);
  endfunction

endpackage

// ===== hw/rtl/sgdm_out_fifo.sv =====
// Output result FIFO that decouples the free-running pipeline from the receiver.
module sgdm_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  sgdm_pkg::result_t push_data,
  input  logic             pop,
  output logic             out_valid,
  output sgdm_pkg::result_t out_data
);
  import sgdm_pkg::*;

  result_t                entries [OUT_FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_CNT_W-1:0]  count;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && out_valid) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop && out_valid);
    end
  end

endmodule

// ===== hw/rtl/sgd_momentum_update_core.sv =====
// Top level: SGD step with weight decay and classic or Nesterov momentum.
//
// Channels: s_axis_* carries one element per beat (index, parameter, gradient);
// m_axis_* returns one beat per element (index, new parameter, new velocity)
// with the saturation flag on tuser. cfg_* writes the four coefficient
// registers (0 learning rate, 1 momentum, 2 decay, 3 Nesterov select).
// Throughput: one element per cycle while s_axis_tready is high, for any mix
// of indices; a repeated index in consecutive beats is served by forwarding
// the fresh velocity into the read-modify-write stage of the velocity RAM.
// The pipeline never stalls; results land in a 16-entry output FIFO and,
// outside the clearing pass, s_axis_tready drops only when 16 elements are in
// flight or waiting, so a stalled receiver holds off the sender without
// losing any beat.
// Reset: registers go to their defaults, then a clearing pass zeroes the
// velocity RAM one entry per cycle with s_axis_tready low; configuration
// writes are taken during that pass.
module sgd_momentum_update_core #(
  parameter int NUM_ELEMENTS = sgdm_pkg::NUM_ELEMENTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [11:0] element_index, [43:12] param_value, [75:44] grad_value
  input  logic [sgdm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [11:0] out_index, [43:12] new_param, [75:44] new_velocity
  output logic [sgdm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] saturated
  output logic                             m_axis_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sgdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sgdm_pkg::COEF_W-1:0]      cfg_data
);
  import sgdm_pkg::*;

  localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  // ceil(2^24 / N): exact quotient for any 12-bit index
  localparam logic [24:0] SLOT_RECIP = 25'(((1 << 24) + NUM_ELEMENTS - 1) / NUM_ELEMENTS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_ELEMENTS - 1);

  // ---------------- configuration ----------------
  logic [COEF_W-1:0] learning_rate;
  logic [COEF_W-1:0] momentum_coef;
  logic [COEF_W-1:0] decay_coef;
  logic              nesterov_mode;
  logic [24:0]       wd_scale;
  logic [47:0]       lw_prod;
  logic [48:0]       lw_round;
  logic              mom_on;
  logic              decay_on;

  assign cfg_ready = 1'b1;
  assign mom_on    = (momentum_coef != '0);
  assign decay_on  = (decay_coef != '0);
  assign lw_prod   = 48'(learning_rate) * 48'(decay_coef);
  assign lw_round  = 49'(lw_prod) + 49'd8388608;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LR_RESET;
      momentum_coef <= '0;
      decay_coef    <= '0;
      nesterov_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LR:    learning_rate <= cfg_data;
        REG_MOM:   momentum_coef <= cfg_data;
        REG_DECAY: decay_coef    <= cfg_data;
        REG_NEST:  nesterov_mode <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  // 1 - lr*wd in Q0.24, follows the registers in the next cycle
  always_ff @(posedge clk) begin
    wd_scale <= 25'd16777216 - 25'(lw_round[48:24]);
  end

  // ---------------- flow control and clearing pass ----------------
  logic                  in_beat;
  logic                  out_beat;
  logic [FIFO_CNT_W-1:0] outstanding;
  logic                  clr_active;
  logic [AW-1:0]         clr_addr;
  logic                  res_valid;
  result_t               res_head;

  assign s_axis_tready = !clr_active && (outstanding < FIFO_CNT_W'(OUT_FIFO_DEPTH));
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_beat      = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      clr_active  <= 1'b1;
      clr_addr    <= '0;
    end else begin
      outstanding <= outstanding + FIFO_CNT_W'(in_beat) - FIFO_CNT_W'(out_beat);
      if (clr_active) begin
        if (clr_addr == LAST_ADDR) begin
          clr_active <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
    end
  end

  // ---------------- pipeline valid bits ----------------
  logic s1_vld, s2_vld, s3_vld, s4_vld, s5_vld, s6_vld, s7_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
    end else begin
      s1_vld <= in_beat;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
      s7_vld <= s6_vld;
    end
  end

  // ---------------- stage 1: slot quotient, decay product ----------------
  logic [IDX_W-1:0]         s1_idx;
  logic signed [DATA_W-1:0] s1_param;
  logic signed [DATA_W-1:0] s1_grad;
  logic [36:0]              q_prod;

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_idx   <= s_axis_tdata[11:0];
      s1_param <= $signed(s_axis_tdata[43:12]);
      s1_grad  <= $signed(s_axis_tdata[75:44]);
    end
  end

  assign q_prod = 37'(s1_idx) * 37'(SLOT_RECIP);

  logic [IDX_W-1:0]         s2_idx;
  logic [IDX_W-1:0]         s2_q;
  logic signed [DATA_W-1:0] s2_param;
  logic signed [DATA_W-1:0] s2_grad;
  logic signed [57:0]       s2_pd;

  always_ff @(posedge clk) begin
    s2_idx   <= s1_idx;
    s2_q     <= q_prod[35:24];
    s2_param <= s1_param;
    s2_grad  <= s1_grad;
    s2_pd    <= mul_q24(34'(s1_param), wd_scale);
  end

  // ---------------- stage 2: slot, RAM read, decayed parameter ----------------
  logic [31:0]              qn;
  logic [31:0]              slot_full;
  logic [AW-1:0]            s2_slot;
  logic signed [33:0]       pd_round;

  assign qn        = 32'(s2_q) * 32'(NUM_ELEMENTS);
  assign slot_full = 32'(s2_idx) - qn;
  assign s2_slot   = slot_full[AW-1:0];
  assign pd_round  = round_q24(s2_pd);

  logic [IDX_W-1:0]         s3_idx;
  logic [AW-1:0]            s3_slot;
  logic signed [DATA_W-1:0] s3_grad;
  logic signed [DATA_W-1:0] s3_p1;
  logic                     s3_flag;

  always_ff @(posedge clk) begin
    s3_idx  <= s2_idx;
    s3_slot <= s2_slot;
    s3_grad <= s2_grad;
    s3_p1   <= decay_on ? sat32(pd_round) : s2_param;
    s3_flag <= decay_on && clip32(pd_round);
  end

  // ---------------- velocity RAM ----------------
  logic signed [DATA_W-1:0] vel_mem [NUM_ELEMENTS];
  logic signed [DATA_W-1:0] rd_data;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic signed [DATA_W-1:0] s3_v1;

  assign mem_we    = clr_active || (s3_vld && mom_on);
  assign mem_waddr = clr_active ? clr_addr : s3_slot;
  assign mem_wdata = clr_active ? '0 : s3_v1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vel_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= vel_mem[s2_slot];
  end

  // ---------------- stage 3: velocity update (read-modify-write) ----------------
  logic                     s4_wr;
  logic [AW-1:0]            s4_slot;
  logic signed [DATA_W-1:0] s4_vel;
  logic signed [DATA_W-1:0] v_old;
  logic signed [33:0]       vm_sum;

  // the element one stage ahead wrote this slot after our read was issued
  assign v_old  = (s4_vld && s4_wr && (s4_slot == s3_slot)) ? s4_vel : rd_data;
  assign vm_sum = round_q24(mul_q24(34'(v_old), 25'(momentum_coef))) + 34'(s3_grad);
  assign s3_v1  = sat32(vm_sum);

  logic [IDX_W-1:0]         s4_idx;
  logic signed [DATA_W-1:0] s4_grad;
  logic signed [DATA_W-1:0] s4_p1;
  logic                     s4_flag;

  always_ff @(posedge clk) begin
    s4_idx  <= s3_idx;
    s4_slot <= s3_slot;
    s4_wr   <= mom_on;
    s4_grad <= s3_grad;
    s4_p1   <= s3_p1;
    s4_vel  <= mom_on ? s3_v1 : v_old;
    s4_flag <= s3_flag || (mom_on && clip32(vm_sum));
  end

  // ---------------- stage 4: Nesterov look-ahead product ----------------
  logic [IDX_W-1:0]         s5_idx;
  logic signed [DATA_W-1:0] s5_grad;
  logic signed [DATA_W-1:0] s5_p1;
  logic signed [DATA_W-1:0] s5_vel;
  logic                     s5_flag;
  logic signed [57:0]       s5_nm;

  always_ff @(posedge clk) begin
    s5_idx  <= s4_idx;
    s5_grad <= s4_grad;
    s5_p1   <= s4_p1;
    s5_vel  <= s4_vel;
    s5_flag <= s4_flag;
    s5_nm   <= mul_q24(34'(s4_vel), 25'(momentum_coef));
  end

  // ---------------- stage 5: step operand select ----------------
  logic signed [33:0]       ng_sum;
  logic                     nest_on;
  logic signed [DATA_W-1:0] step_src;

  assign ng_sum   = round_q24(s5_nm) + 34'(s5_grad);
  assign nest_on  = mom_on && nesterov_mode;
  assign step_src = nest_on ? sat32(ng_sum) : (mom_on ? s5_vel : s5_grad);

  logic [IDX_W-1:0]         s6_idx;
  logic signed [DATA_W-1:0] s6_p1;
  logic signed [DATA_W-1:0] s6_vel;
  logic                     s6_flag;
  logic signed [DATA_W-1:0] s6_src;

  always_ff @(posedge clk) begin
    s6_idx  <= s5_idx;
    s6_p1   <= s5_p1;
    s6_vel  <= s5_vel;
    s6_flag <= s5_flag || (nest_on && clip32(ng_sum));
    s6_src  <= step_src;
  end

  // ---------------- stage 6: step product ----------------
  logic [IDX_W-1:0]         s7_idx;
  logic signed [DATA_W-1:0] s7_p1;
  logic signed [DATA_W-1:0] s7_vel;
  logic                     s7_flag;
  logic signed [57:0]       s7_sp;

  always_ff @(posedge clk) begin
    s7_idx  <= s6_idx;
    s7_p1   <= s6_p1;
    s7_vel  <= s6_vel;
    s7_flag <= s6_flag;
    s7_sp   <= mul_q24(34'(s6_src), 25'(learning_rate));
  end

  // ---------------- stage 7: parameter update ----------------
  logic signed [33:0] p_diff;
  result_t            res_in;

  assign p_diff = 34'(s7_p1) - round_q24(s7_sp);

  always_comb begin
    res_in.idx          = s7_idx;
    res_in.new_param    = sat32(p_diff);
    res_in.new_velocity = s7_vel;
    res_in.saturated    = s7_flag || clip32(p_diff);
  end

  sgdm_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s7_vld),
    .push_data (res_in),
    .pop       (m_axis_tready),
    .out_valid (res_valid),
    .out_data  (res_head)
  );

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {4'b0000, res_head.new_velocity, res_head.new_param, res_head.idx};
  assign m_axis_tuser  = res_head.saturated;

endmodule
